// File: rtl/cfus_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfus_pkg: shared constants, types and tables
// Reciprocals for the constant divisions, pipeline depth, stage payloads.
// ----------------------------------------------------------------------------
package cfus_pkg;

  // Total register stages from input word to output word.
  localparam int unsigned LAT = 10;

  // t / 86400 = (t >> 7) / 675; reciprocal floor(2^32 / 675)
  localparam logic [22:0] DAY_RCP   = 23'd6362914;
  localparam logic [9:0]  DAY_ODD   = 10'd675;

  // Civil-date constants
  localparam logic [19:0] EPOCH_OFS = 20'd719468;
  localparam logic [17:0] ERA_DAYS  = 18'd146097;
  localparam logic [14:0] ERA_RCP   = 15'd29398;   // floor(2^32 / 146097)
  localparam logic [10:0] Q4Y_DAYS  = 11'd1460;
  localparam logic [17:0] Q4Y_RCP   = 18'd183859;  // floor(2^28 / 1460)
  localparam logic [17:0] CENT_DAYS = 18'd36524;
  localparam logic [17:0] ERA_LAST  = 18'd146096;
  localparam logic [8:0]  YEAR_DAYS = 9'd365;
  localparam logic [18:0] YEAR_RCP  = 19'd367719;  // floor(2^27 / 365)
  localparam logic [11:0] ERA_YEARS = 12'd400;
  localparam logic [11:0] RTC_BASE  = 12'd2000;

  // Time-of-day constants
  localparam logic [11:0] HOUR_SECS = 12'd3600;
  localparam logic [12:0] HOUR_RCP  = 13'd4660;    // floor(2^24 / 3600)
  localparam logic [5:0]  MIN_SECS  = 6'd60;
  localparam logic [12:0] MIN_RCP   = 13'd4369;    // floor(2^18 / 60)
  localparam logic [16:0] WEEK_RCP  = 17'd74898;   // floor(2^19 / 7)
  localparam logic [2:0]  WEEK_DAYS = 3'd7;
  localparam logic [16:0] WEEK_OFS  = 17'd3;       // day 0 was a Thursday

  typedef struct packed {
    logic [11:0] full_year;
    logic [7:0]  rtc_year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
  } cfus_date_t;

  typedef struct packed {
    logic [2:0] weekday;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } cfus_time_t;

  // First day-of-year (March-based) of each shifted month index.
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

// File: rtl/cfus_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfus_ifs: valid/ready channels
// Timestamp input channel and calendar result channel.
// ----------------------------------------------------------------------------
interface cfus_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] unix_seconds;

  modport source (output valid, output unix_seconds, input ready);
  modport sink   (input valid, input unix_seconds, output ready);
endinterface

interface cfus_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] full_year;
  logic [7:0]  rtc_year;
  logic [3:0]  month;
  logic [4:0]  day_of_month;
  logic [2:0]  weekday;
  logic [4:0]  hours;
  logic [5:0]  minutes;
  logic [5:0]  seconds;

  modport source (output valid, output full_year, output rtc_year, output month,
                  output day_of_month, output weekday, output hours,
                  output minutes, output seconds, input ready);
  modport sink   (input valid, input full_year, input rtc_year, input month,
                  input day_of_month, input weekday, input hours,
                  input minutes, input seconds, output ready);
endinterface

// File: rtl/cfus_split.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfus_split: day / time-of-day split
// Two stages: reciprocal multiply, then remainder with one correction.
// ----------------------------------------------------------------------------
module cfus_split import cfus_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] unix_seconds,
  output logic [15:0] days,
  output logic [16:0] tod
);

  logic [24:0] x_r;
  logic [6:0]  lo_r;
  logic [47:0] prod_r;
  logic [15:0] days_r;
  logic [16:0] tod_r;

  logic [15:0] q0;
  logic [24:0] r0;
  logic        ge;
  logic [9:0]  rem;

  always_comb begin
    q0  = prod_r[47:32];
    r0  = x_r - 25'(q0) * 25'(DAY_ODD);
    ge  = (r0 >= 25'(DAY_ODD));
    rem = ge ? 10'(r0 - 25'(DAY_ODD)) : 10'(r0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= unix_seconds[31:7];
      lo_r   <= unix_seconds[6:0];
      prod_r <= 48'(unix_seconds[31:7]) * 48'(DAY_RCP);
      days_r <= q0 + 16'(ge);
      tod_r  <= {rem, lo_r};
    end
  end

  assign days = days_r;
  assign tod  = tod_r;

endmodule

// File: rtl/cfus_clock.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfus_clock: hours, minutes, seconds and weekday
// Four working stages, then a delay line to match the date path.
// ----------------------------------------------------------------------------
module cfus_clock import cfus_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] days,
  input  logic [16:0] tod,
  output cfus_time_t  tm
);

  localparam int unsigned PAD = LAT - 6;

  // stage 3
  logic [16:0] tod3_r;
  logic [29:0] p_hr_r;
  logic [16:0] wk_r;
  logic [33:0] p_wk_r;
  // stage 4
  logic [11:0] hrem_r;
  logic [4:0]  hours4_r;
  logic [2:0]  wday4_r;
  // stage 5
  logic [11:0] hrem5_r;
  logic [24:0] p_min_r;
  logic [4:0]  hours5_r;
  logic [2:0]  wday5_r;
  // stage 6 and delay line
  cfus_time_t  dly_r [PAD+1];

  logic [16:0] wk;
  logic [5:0]  hq0;
  logic [16:0] hr0;
  logic        hge;
  logic [14:0] wq0;
  logic [16:0] wr0;
  logic [2:0]  wrem;
  logic [6:0]  mq0;
  logic [11:0] mr0;
  logic        mge;
  cfus_time_t  tm6;

  always_comb begin
    wk   = 17'(days) + WEEK_OFS;
    hq0  = p_hr_r[29:24];
    hr0  = tod3_r - 17'(hq0) * 17'(HOUR_SECS);
    hge  = (hr0 >= 17'(HOUR_SECS));
    wq0  = p_wk_r[33:19];
    wr0  = wk_r - 17'(wq0) * 17'(WEEK_DAYS);
    wrem = (wr0 >= 17'(WEEK_DAYS)) ? 3'(wr0 - 17'(WEEK_DAYS)) : 3'(wr0);
    mq0  = p_min_r[24:18];
    mr0  = hrem5_r - 12'(mq0) * 12'(MIN_SECS);
    mge  = (mr0 >= 12'(MIN_SECS));
    tm6.weekday = wday5_r;
    tm6.hours   = hours5_r;
    tm6.minutes = 6'(mq0) + 6'(mge);
    tm6.seconds = mge ? 6'(mr0 - 12'(MIN_SECS)) : 6'(mr0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tod3_r   <= tod;
      p_hr_r   <= 30'(tod) * 30'(HOUR_RCP);
      wk_r     <= wk;
      p_wk_r   <= 34'(wk) * 34'(WEEK_RCP);
      hours4_r <= 5'(hq0) + 5'(hge);
      hrem_r   <= hge ? 12'(hr0 - 17'(HOUR_SECS)) : 12'(hr0);
      wday4_r  <= wrem + 3'd1;
      hrem5_r  <= hrem_r;
      p_min_r  <= 25'(hrem_r) * 25'(MIN_RCP);
      hours5_r <= hours4_r;
      wday5_r  <= wday4_r;
      dly_r[0] <= tm6;
      for (int i = 1; i <= PAD; i++) begin
        dly_r[i] <= dly_r[i-1];
      end
    end
  end

  assign tm = dly_r[PAD];

endmodule

// File: rtl/cfus_date.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfus_date: day count to Gregorian year, month, day
// Eight stages: era split, 4-year/century terms, year of era, month lookup.
// ----------------------------------------------------------------------------
module cfus_date import cfus_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] days,
  output cfus_date_t  dt
);

  // stage 3
  logic [19:0] z_r;
  logic [34:0] p_era_r;
  // stage 4
  logic [17:0] doe4_r;
  logic [2:0]  era4_r;
  // stage 5
  logic [17:0] doe5_r;
  logic [35:0] p_a_r;
  logic [2:0]  b5_r;
  logic        c5_r;
  logic [2:0]  era5_r;
  // stage 6
  logic [17:0] n6_r;
  logic [17:0] doe6_r;
  logic [2:0]  era6_r;
  // stage 7
  logic [17:0] n7_r;
  logic [36:0] p_y_r;
  logic [17:0] doe7_r;
  logic [2:0]  era7_r;
  // stage 8
  logic [8:0]  yoe8_r;
  logic [17:0] doe8_r;
  logic [2:0]  era8_r;
  // stage 9
  logic [8:0]  doy9_r;
  logic [8:0]  yoe9_r;
  logic [2:0]  era9_r;
  // stage 10
  cfus_date_t  dt_r;

  logic [19:0] z;
  logic [2:0]  eq0;
  logic [19:0] doe0;
  logic        ege;
  logic [2:0]  bcnt;
  logic [7:0]  a0;
  logic [17:0] ra;
  logic [7:0]  a;
  logic [9:0]  yq0;
  logic [17:0] ry;
  logic [1:0]  c100;
  logic [17:0] ybase;
  logic [3:0]  mp;
  logic [3:0]  m;
  logic [11:0] y;
  cfus_date_t  dt10;

  always_comb begin
    z    = 20'(days) + EPOCH_OFS;
    eq0  = p_era_r[34:32];
    doe0 = z_r - 20'(eq0) * 20'(ERA_DAYS);
    ege  = (doe0 >= 20'(ERA_DAYS));

    bcnt = 3'(doe4_r >= CENT_DAYS) + 3'(doe4_r >= 18'(2 * CENT_DAYS))
         + 3'(doe4_r >= 18'(3 * CENT_DAYS)) + 3'(doe4_r >= ERA_LAST);

    a0 = p_a_r[35:28];
    ra = doe5_r - 18'(a0) * 18'(Q4Y_DAYS);
    a  = a0 + 8'(ra >= 18'(Q4Y_DAYS));

    yq0 = p_y_r[36:27];
    ry  = n7_r - 18'(yq0) * 18'(YEAR_DAYS);

    c100  = 2'(yoe8_r >= 9'd100) + 2'(yoe8_r >= 9'd200) + 2'(yoe8_r >= 9'd300);
    ybase = 18'(yoe8_r) * 18'(YEAR_DAYS) + 18'(yoe8_r[8:2]) - 18'(c100);

    mp = '0;
    for (int k = 1; k < 12; k++) begin
      mp = mp + 4'(doy9_r >= month_start(4'(k)));
    end
    m = (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
    y = 12'(yoe9_r) + 12'(era9_r) * ERA_YEARS + 12'(m <= 4'd2);
    dt10.full_year    = y;
    dt10.rtc_year     = 8'(y - RTC_BASE);
    dt10.month        = m;
    dt10.day_of_month = 5'(doy9_r - month_start(mp) + 9'd1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z_r     <= z;
      p_era_r <= 35'(z) * 35'(ERA_RCP);

      doe4_r  <= ege ? 18'(doe0 - 20'(ERA_DAYS)) : 18'(doe0);
      era4_r  <= eq0 + 3'(ege);

      doe5_r  <= doe4_r;
      p_a_r   <= 36'(doe4_r) * 36'(Q4Y_RCP);
      b5_r    <= bcnt;
      c5_r    <= (doe4_r == ERA_LAST);
      era5_r  <= era4_r;

      n6_r    <= doe5_r - 18'(a) + 18'(b5_r) - 18'(c5_r);
      doe6_r  <= doe5_r;
      era6_r  <= era5_r;

      n7_r    <= n6_r;
      p_y_r   <= 37'(n6_r) * 37'(YEAR_RCP);
      doe7_r  <= doe6_r;
      era7_r  <= era6_r;

      yoe8_r  <= 9'(yq0) + 9'(ry >= 18'(YEAR_DAYS));
      doe8_r  <= doe7_r;
      era8_r  <= era7_r;

      doy9_r  <= 9'(doe8_r - ybase);
      yoe9_r  <= yoe8_r;
      era9_r  <= era8_r;

      dt_r    <= dt10;
    end
  end

  assign dt = dt_r;

endmodule

// File: rtl/calendar_from_unix_seconds.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_from_unix_seconds: Unix seconds to civil UTC date and time
// Ten-stage pipeline; one timestamp word in and one calendar word out per
// clock while the output is not stalled.
// ----------------------------------------------------------------------------
// Converts an unsigned 32-bit Unix timestamp (UTC) into a Gregorian date,
// weekday (1 = Monday .. 7 = Sunday) and time of day. Every input value is
// legal; the range covers 1970-01-01 through 2106-02-07 06:28:15. The block
// keeps no state between words. Throughput is one word per cycle, set by the
// ten register stages that all advance together. The whole pipeline holds
// while the output word is stalled, so in_if.ready follows out_if.ready
// whenever the last stage is occupied; bubbles inside the pipe are not
// squeezed out. Divisions by the day, era, 4-year, year, hour, minute and week
// lengths are a reciprocal multiply in one stage followed by a remainder and
// single correction in the next; century and month terms use comparisons.
// ----------------------------------------------------------------------------
module calendar_from_unix_seconds import cfus_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  cfus_in_if.sink    in_if,
  cfus_out_if.source out_if
);

  logic [LAT-1:0] vld_r;
  logic [LAT-1:0] vld_nxt;
  logic           en;

  logic [15:0]    days;
  logic [16:0]    tod;
  cfus_date_t     dt;
  cfus_time_t     tm;

  // Global advance: move when the output slot is empty or being taken.
  assign en          = !vld_r[LAT-1] || out_if.ready;
  assign in_if.ready = en;

  always_comb begin
    vld_nxt = {vld_r[LAT-2:0], in_if.valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // Stages 1-2: days and seconds of day
  cfus_split u_split (
    .clk          (clk),
    .en           (en),
    .unix_seconds (in_if.unix_seconds),
    .days         (days),
    .tod          (tod)
  );

  // Stages 3-10: calendar date
  cfus_date u_date (
    .clk  (clk),
    .en   (en),
    .days (days),
    .dt   (dt)
  );

  // Stages 3-10: time of day and weekday, padded to the date latency
  cfus_clock u_clock (
    .clk  (clk),
    .en   (en),
    .days (days),
    .tod  (tod),
    .tm   (tm)
  );

  assign out_if.valid        = vld_r[LAT-1];
  assign out_if.full_year    = dt.full_year;
  assign out_if.rtc_year     = dt.rtc_year;
  assign out_if.month        = dt.month;
  assign out_if.day_of_month = dt.day_of_month;
  assign out_if.weekday      = tm.weekday;
  assign out_if.hours        = tm.hours;
  assign out_if.minutes      = tm.minutes;
  assign out_if.seconds      = tm.seconds;

  // A stalled pipe keeps its occupancy.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline occupancy changed during stall");

  // An idle input cycle leaves a bubble in the first stage.
  a_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    en && !in_if.valid |=> !vld_r[0])
    else $error("first stage valid without accepted word");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> out_if.month >= 4'd1 && out_if.month <= 4'd12 &&
                     out_if.day_of_month >= 5'd1 &&
                     out_if.full_year >= 12'd1970 && out_if.full_year <= 12'd2106)
    else $error("date field out of range");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> out_if.weekday >= 3'd1 && out_if.weekday <= 3'd7 &&
                     out_if.hours <= 5'd23 && out_if.minutes <= 6'd59 &&
                     out_if.seconds <= 6'd59)
    else $error("time field out of range");

  a_rtc_year: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> out_if.rtc_year == 8'(out_if.full_year - RTC_BASE))
    else $error("rtc year does not match full year");

endmodule

// File: tb/calendar_from_unix_seconds_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_from_unix_seconds_checker: result scoreboard for the converter
// Watches both channels. Each accepted timestamp is converted to its civil
// date and time here, and each result word is compared against the oldest one.
// ----------------------------------------------------------------------------
module calendar_from_unix_seconds_checker import cfus_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  cfus_in_if          in_mon,
  cfus_out_if         out_mon,
  output int unsigned fail_count,
  output int unsigned pending_count,
  output int unsigned checked_count
);

  localparam int unsigned SECS_IN_DAY  = 32'd86400;
  localparam int unsigned SHIFT_TO_MAR = 32'd719468;   // days from 0000-03-01
  localparam int unsigned DAYS_IN_ERA  = 32'd146097;
  localparam int unsigned SECS_IN_HOUR = 32'd3600;
  localparam int unsigned REPORT_MAX   = 10;

  typedef struct packed {
    cfus_date_t date;
    cfus_time_t tod;
  } calendar_word_t;

  calendar_word_t expected_dates[$];
  int unsigned    fails;
  int unsigned    checked;

  // Era-based day count to civil date; the year starts on March 1 here.
  function automatic calendar_word_t civil_from_stamp(input logic [31:0] stamp);
    int unsigned    days, tod, z, era, doe, yoe, doy, mp, dom, mon, yr;
    calendar_word_t w;
    days = stamp / SECS_IN_DAY;
    tod  = stamp % SECS_IN_DAY;
    z    = days + SHIFT_TO_MAR;
    era  = z / DAYS_IN_ERA;
    doe  = z - era * DAYS_IN_ERA;
    yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp   = (5 * doy + 2) / 153;
    dom  = doy - (153 * mp + 2) / 5 + 1;
    mon  = (mp < 10) ? mp + 3 : mp - 9;
    yr   = yoe + era * 400 + ((mon <= 2) ? 1 : 0);
    w.date.full_year    = 12'(yr);
    w.date.rtc_year     = 8'(yr - 2000);
    w.date.month        = 4'(mon);
    w.date.day_of_month = 5'(dom);
    w.tod.weekday       = 3'((days + 3) % 7 + 1);   // epoch day was a Thursday
    w.tod.hours         = 5'(tod / SECS_IN_HOUR);
    w.tod.minutes       = 6'((tod / 60) % 60);
    w.tod.seconds       = 6'(tod % 60);
    return w;
  endfunction

  initial begin
    fails         = 0;
    checked       = 0;
    fail_count    = 0;
    pending_count = 0;
    checked_count = 0;
  end

  always @(posedge clk) begin
    calendar_word_t want, got;
    logic           bad;
    if (rst_n) begin
      // Retire first: a word leaving now can never belong to one entering now.
      if (out_mon.valid && out_mon.ready) begin
        got.date.full_year    = out_mon.full_year;
        got.date.rtc_year     = out_mon.rtc_year;
        got.date.month        = out_mon.month;
        got.date.day_of_month = out_mon.day_of_month;
        got.tod.weekday       = out_mon.weekday;
        got.tod.hours         = out_mon.hours;
        got.tod.minutes       = out_mon.minutes;
        got.tod.seconds       = out_mon.seconds;
        if (expected_dates.size() == 0) begin
          fails++;
          if (fails <= REPORT_MAX)
            $display("%0t: unexpected result word %0d-%0d-%0d", $realtime,
                     got.date.full_year, got.date.month, got.date.day_of_month);
        end else begin
          want = expected_dates.pop_front();
          checked++;
          bad = (got.date.full_year    !== want.date.full_year)    ||
                (got.date.rtc_year     !== want.date.rtc_year)     ||
                (got.date.month        !== want.date.month)        ||
                (got.date.day_of_month !== want.date.day_of_month) ||
                (got.tod.weekday       !== want.tod.weekday)       ||
                (got.tod.hours         !== want.tod.hours)         ||
                (got.tod.minutes       !== want.tod.minutes)       ||
                (got.tod.seconds       !== want.tod.seconds);
          if (bad) begin
            fails++;
            if (fails <= REPORT_MAX) begin
              $display("%0t: mismatch exp %0d-%0d-%0d rtc=%0d wd=%0d %0d:%0d:%0d",
                       $realtime, want.date.full_year, want.date.month,
                       want.date.day_of_month, want.date.rtc_year, want.tod.weekday,
                       want.tod.hours, want.tod.minutes, want.tod.seconds);
              $display("%0t:          got %0d-%0d-%0d rtc=%0d wd=%0d %0d:%0d:%0d",
                       $realtime, got.date.full_year, got.date.month,
                       got.date.day_of_month, got.date.rtc_year, got.tod.weekday,
                       got.tod.hours, got.tod.minutes, got.tod.seconds);
            end
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_dates.push_back(civil_from_stamp(in_mon.unix_seconds));
    end
    fail_count    <= fails;
    checked_count <= checked;
    pending_count <= expected_dates.size();
  end

endmodule

// File: tb/calendar_from_unix_seconds_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_from_unix_seconds_tb: top of the converter testbench
// Drives timestamps with random pacing and random output backpressure; a
// separate checker converts every accepted timestamp and scores the results.
// ----------------------------------------------------------------------------
module calendar_from_unix_seconds_tb;
  import cfus_pkg::*;

  localparam int unsigned IDLE_LIMIT  = 4000;  // cycles without any handshake
  localparam int unsigned RANDOM_WORDS = 1850;
  localparam int unsigned BLOCK_WORDS  = 50;   // pacing mode changes per block
  localparam int unsigned N_DIRECTED   = 24;

  logic clk;
  logic rst_n;

  cfus_in_if  in_if ();
  cfus_out_if out_if ();

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned checked_count;
  int unsigned words_sent;
  int unsigned idle_cycles;
  int unsigned stall_left;
  bit          no_idle;   // set during burst stretches: no gaps on either side

  // Directed timestamps: range ends, second/minute/hour/day rollovers, leap
  // days (ordinary, century divisible by 400, and the skipped one in 2100),
  // year ends around the RTC year wrap, the signed 32-bit rollover, and the
  // last representable second in 2106.
  logic [31:0] directed_stamps [N_DIRECTED] = '{
    32'd0,          32'd1,          32'd59,         32'd60,
    32'd3599,       32'd3600,       32'd86399,      32'd86400,
    32'd68169600,   32'd946684799,  32'd946684800,  32'd951782400,
    32'd951868800,  32'd978307199,  32'd1234567890, 32'd2147483647,
    32'd2147483648, 32'd4102444799, 32'd4107456000, 32'd4107542400,
    32'd4294943999, 32'd4294944000, 32'd4294967294, 32'd4294967295
  };

  calendar_from_unix_seconds u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  calendar_from_unix_seconds_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_if),
    .out_mon       (out_if),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .checked_count (checked_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Gap length: mostly none, some short, a few long.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60)      return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else             return $urandom_range(20, 40);
  endfunction

  // Offer one timestamp word and hold it until the block takes it. Valid is
  // only dropped when a gap is inserted, so back-to-back words keep it high.
  task automatic offer_stamp(input logic [31:0] stamp);
    int unsigned gap;
    gap = no_idle ? 0 : idle_len();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.unix_seconds <= stamp;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    words_sent++;
  endtask

  // Random timestamp, biased toward day boundaries and both ends of the range.
  function automatic logic [31:0] random_stamp();
    logic [31:0] day_start;
    case ($urandom_range(0, 9))
      6, 7: begin
        day_start = 32'($urandom_range(0, 49710)) * 32'd86400;
        case ($urandom_range(0, 3))
          0:       return day_start;
          1:       return day_start - 32'd1;   // last second of the day before
          2:       return day_start + 32'd86399;
          default: return day_start + 32'($urandom_range(0, 86399));
        endcase
      end
      8:       return 32'($urandom_range(0, 32'h0010_0000));
      9:       return 32'hFFFF_FFFF - 32'($urandom_range(0, 32'h0010_0000));
      default: return $urandom();
    endcase
  endfunction

  // Output backpressure: random stalls, off during burst stretches.
  always @(posedge clk) begin
    int unsigned gap;
    if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      gap = no_idle ? 0 : idle_len();
      if (gap != 0) begin
        out_if.ready <= 1'b0;
        stall_left   <= gap - 1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: a stretch with no handshake on either side means a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                 $realtime, IDLE_LIMIT, pending_count);
        $display("[calendar_from_unix_seconds] ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.unix_seconds = 32'd0;
    out_if.ready       = 1'b0;
    stall_left         = 0;
    idle_cycles        = 0;
    words_sent         = 0;
    no_idle            = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_stamps[i]) offer_stamp(directed_stamps[i]);

    // Random words in blocks; about a quarter of the blocks run with no gaps
    // at all so the pipe also sees long full-rate stretches.
    for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
      if (n % BLOCK_WORDS == 0) no_idle = ($urandom_range(0, 3) == 0);
      offer_stamp(random_stamp());
    end
    in_if.valid <= 1'b0;
    no_idle = 1'b1;

    // Drain: wait until every sent word has been checked, then keep running so
    // that any stray result words can still show up.
    while (checked_count < words_sent) @(posedge clk);
    repeat (LAT + 4) @(posedge clk);

    $display("run covered %0d timestamps (%0d directed), %0d result words checked",
             words_sent, N_DIRECTED, checked_count);
    $display("pacing: random source gaps and sink stalls, with gap-free bursts");
    if (fail_count == 0 && pending_count == 0) begin
      $display("[calendar_from_unix_seconds] OK");
    end else begin
      $display("%0d failures, %0d results outstanding", fail_count, pending_count);
      $display("[calendar_from_unix_seconds] ERROR");
    end
    $finish;
  end

endmodule
